@@ hdl/gqp_pkg.sv @@
`default_nettype none
package gqp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIM_W  = 11;
  localparam int CMP_W  = ((COL_W > ROW_W) ? ((COL_W > DIM_W) ? COL_W : DIM_W)
                                           : ((ROW_W > DIM_W) ? ROW_W : DIM_W)) + 1;
  localparam int CNT_W  = 30;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic             blocked;
    logic [COL_W-1:0] pos;
    logic             first_row;
    logic             first_col;
    logic             last;
  } cell_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [CNT_W-1:0] vert;
    logic [CNT_W-1:0] diag;
  } lwr_t;

  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MOD}) begin
      s = s - {1'b0, PATH_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/gqp_if.sv @@
`default_nettype none
interface gqp_in_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, output blocked, input ready);
  modport sink (input valid, input blocked, output ready);
endinterface

interface gqp_out_if;
  logic                       valid;
  logic                       ready;
  logic [gqp_pkg::CNT_W-1:0]  path_count;
  logic                       is_last;

  modport source (output valid, output path_count, output is_last, input ready);
  modport sink (input valid, input path_count, input is_last, output ready);
endinterface
`default_nettype wire

@@ hdl/grid_queen_path_count_dp_unit.sv @@
`default_nettype none
// channel   dir  handshake      payload
// in_ch     in   valid/ready    blocked
// out_ch    out  valid/ready    path_count[29:0], is_last
// cfg apb   in   psel/penable   paddr[2:0], pwdata, prdata (grid_width @0, grid_height @4)
//
// one cell per cycle sustained while the result is taken; each request passes the cell stage,
// where the line store read lands, then the result stage, which registers the modular sums
// synchronous active-low reset clears control and runs, line stores are not cleared
// a stalled result holds the cell stage, input stalls only when both stages are full
module grid_queen_path_count_dp_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  gqp_in_if.sink                            in_ch,
  gqp_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gqp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gqp_pkg::DATA_W-1:0]   pwdata,
  output logic      [gqp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  gqp_pkg::cfg_t             cfg;
  gqp_pkg::cell_t            cur;
  gqp_pkg::lwr_t             lwr;
  logic                      in_accept;
  logic [gqp_pkg::CNT_W-1:0] vert_rd;
  logic [gqp_pkg::CNT_W-1:0] diag_rd;

  assign in_accept = in_ch.valid && in_ch.ready;

  gqp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gqp_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (in_accept),
    .blocked (in_ch.blocked),
    .cur     (cur)
  );

  gqp_ram #(
    .WIDTH (gqp_pkg::CNT_W),
    .DEPTH (gqp_pkg::MAX_WIDTH)
  ) u_vert_ram (
    .clk     (clk),
    .wr_en   (lwr.en),
    .wr_addr (lwr.addr),
    .wr_data (lwr.vert),
    .rd_en   (in_accept),
    .rd_addr (cur.pos),
    .rd_data (vert_rd)
  );

  gqp_ram #(
    .WIDTH (gqp_pkg::CNT_W),
    .DEPTH (gqp_pkg::MAX_WIDTH)
  ) u_diag_ram (
    .clk     (clk),
    .wr_en   (lwr.en),
    .wr_addr (lwr.addr),
    .wr_data (lwr.diag),
    .rd_en   (in_accept),
    .rd_addr (cur.pos),
    .rd_data (diag_rd)
  );

  gqp_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg.restart),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .cur        (cur),
    .vert_rd    (vert_rd),
    .diag_rd    (diag_rd),
    .lwr        (lwr),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .path_count (out_ch.path_count),
    .is_last    (out_ch.is_last)
  );

  a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.path_count < gqp_pkg::PATH_MOD)
    else $error("path count not reduced");

  a_restart_goal: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.restart |=> cur.first_row && cur.first_col)
    else $error("register write did not restart the grid");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && cur.last && !cfg.restart |=> cur.first_row && cur.first_col)
    else $error("grid did not wrap after last cell");

endmodule
`default_nettype wire

@@ hdl/gqp_ram.sv @@
`default_nettype none
module gqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/gqp_cfg.sv @@
`default_nettype none
module gqp_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gqp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gqp_pkg::DATA_W-1:0]   pwdata,
  output logic      [gqp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output gqp_pkg::cfg_t                     cfg
);

  logic [gqp_pkg::DIM_W-1:0] width_r;
  logic [gqp_pkg::DIM_W-1:0] width_nxt;
  logic [gqp_pkg::DIM_W-1:0] height_r;
  logic [gqp_pkg::DIM_W-1:0] height_nxt;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr) begin
      case (paddr[2])
        gqp_pkg::REG_GRID_WIDTH:  width_nxt  = pwdata[gqp_pkg::DIM_W-1:0];
        gqp_pkg::REG_GRID_HEIGHT: height_nxt = pwdata[gqp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gqp_pkg::DIM_W'(1);
      height_r <= gqp_pkg::DIM_W'(1);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      gqp_pkg::REG_GRID_WIDTH:  prdata = gqp_pkg::DATA_W'(width_r);
      gqp_pkg::REG_GRID_HEIGHT: prdata = gqp_pkg::DATA_W'(height_r);
      default:                  prdata = '0;
    endcase
  end

  // zero acts as one, oversize width acts as the store depth, oversize height as MAX_HEIGHT
  always_comb begin
    if (width_r == '0) begin
      cfg.width_eff = gqp_pkg::DIM_W'(1);
    end else if (32'(width_r) > 32'(gqp_pkg::MAX_WIDTH)) begin
      cfg.width_eff = gqp_pkg::DIM_W'(gqp_pkg::MAX_WIDTH);
    end else begin
      cfg.width_eff = width_r;
    end
    if (height_r == '0) begin
      cfg.height_eff = gqp_pkg::DIM_W'(1);
    end else if (32'(height_r) > 32'(gqp_pkg::MAX_HEIGHT)) begin
      cfg.height_eff = gqp_pkg::DIM_W'(gqp_pkg::MAX_HEIGHT);
    end else begin
      cfg.height_eff = height_r;
    end
    cfg.restart = wr && (paddr[2] == gqp_pkg::REG_GRID_WIDTH ||
                         paddr[2] == gqp_pkg::REG_GRID_HEIGHT);
  end

endmodule
`default_nettype wire

@@ hdl/gqp_scan.sv @@
`default_nettype none
module gqp_scan (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gqp_pkg::cfg_t         cfg,
  input  wire logic                  accept,
  input  wire logic                  blocked,
  output gqp_pkg::cell_t             cur
);

  logic [gqp_pkg::COL_W-1:0] col_r;
  logic [gqp_pkg::COL_W-1:0] col_nxt;
  logic [gqp_pkg::ROW_W-1:0] row_r;
  logic [gqp_pkg::ROW_W-1:0] row_nxt;
  logic [gqp_pkg::COL_W-1:0] pos;
  logic                      row_end;
  logic                      grid_end;

  always_comb begin
    if (gqp_pkg::CMP_W'(col_r) >= gqp_pkg::CMP_W'(cfg.width_eff)) begin
      pos = '0;
    end else begin
      pos = col_r;
    end
    row_end  = gqp_pkg::CMP_W'(pos) + gqp_pkg::CMP_W'(1)
               >= gqp_pkg::CMP_W'(cfg.width_eff);
    grid_end = gqp_pkg::CMP_W'(row_r) + gqp_pkg::CMP_W'(1)
               >= gqp_pkg::CMP_W'(cfg.height_eff);

    cur.blocked   = blocked;
    cur.pos       = pos;
    cur.first_row = (row_r == '0);
    cur.first_col = (col_r == '0);
    cur.last      = row_end && grid_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = grid_end ? '0 : row_r + gqp_pkg::ROW_W'(1);
      end else begin
        col_nxt = pos + gqp_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/gqp_calc.sv @@
`default_nettype none
module gqp_calc (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        restart,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire gqp_pkg::cell_t              cur,
  input  wire logic [gqp_pkg::CNT_W-1:0]   vert_rd,
  input  wire logic [gqp_pkg::CNT_W-1:0]   diag_rd,
  output gqp_pkg::lwr_t                    lwr,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [gqp_pkg::CNT_W-1:0]   path_count,
  output logic                             is_last
);

  // cell stage, line store read data arrives here
  gqp_pkg::cell_t            cell_r;
  logic                      cell_vld_r;
  logic                      cell_vld_nxt;
  logic                      byp_r;
  logic [gqp_pkg::CNT_W-1:0] byp_v_r;
  logic [gqp_pkg::CNT_W-1:0] byp_d_r;
  logic [gqp_pkg::CNT_W-1:0] h_run_r;
  logic [gqp_pkg::CNT_W-1:0] d_hold_r;

  // result stage
  logic                      res_vld_r;
  logic                      res_vld_nxt;
  logic [gqp_pkg::CNT_W-1:0] res_cnt_r;
  logic                      res_last_r;

  logic                      accept;
  logic                      res_free;
  logic                      cell_move;
  logic [gqp_pkg::CNT_W-1:0] v_mem;
  logic [gqp_pkg::CNT_W-1:0] d_mem;
  logic [gqp_pkg::CNT_W-1:0] v_in;
  logic [gqp_pkg::CNT_W-1:0] d_old;
  logic [gqp_pkg::CNT_W-1:0] h_in;
  logic [gqp_pkg::CNT_W-1:0] d_in;
  logic [gqp_pkg::CNT_W-1:0] cnt;
  logic [gqp_pkg::CNT_W-1:0] v_new;
  logic [gqp_pkg::CNT_W-1:0] h_new;
  logic [gqp_pkg::CNT_W-1:0] d_new;

  assign res_free  = !res_vld_r || out_ready;
  assign cell_move = cell_vld_r && res_free;
  assign in_ready  = !cell_vld_r || res_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    v_mem = byp_r ? byp_v_r : vert_rd;
    d_mem = byp_r ? byp_d_r : diag_rd;
    v_in  = cell_r.first_row ? '0 : v_mem;
    d_old = cell_r.first_row ? '0 : d_mem;
    h_in  = cell_r.first_col ? '0 : h_run_r;
    d_in  = cell_r.first_col ? '0 : d_hold_r;
    if (cell_r.first_row && cell_r.first_col) begin
      // goal cell
      cnt   = gqp_pkg::CNT_W'(1);
      v_new = gqp_pkg::CNT_W'(1);
      h_new = gqp_pkg::CNT_W'(1);
      d_new = gqp_pkg::CNT_W'(1);
    end else if (cell_r.blocked) begin
      cnt   = '0;
      v_new = '0;
      h_new = '0;
      d_new = '0;
    end else begin
      cnt   = gqp_pkg::mod_add(gqp_pkg::mod_add(v_in, h_in), d_in);
      v_new = gqp_pkg::mod_add(v_in, cnt);
      h_new = gqp_pkg::mod_add(h_in, cnt);
      d_new = gqp_pkg::mod_add(d_in, cnt);
    end
  end

  always_comb begin
    lwr.en   = cell_move;
    lwr.addr = cell_r.pos;
    lwr.vert = v_new;
    lwr.diag = d_new;
  end

  always_comb begin
    cell_vld_nxt = cell_vld_r;
    if (accept) begin
      cell_vld_nxt = 1'b1;
    end else if (cell_move) begin
      cell_vld_nxt = 1'b0;
    end
    res_vld_nxt = res_vld_r;
    if (cell_move) begin
      res_vld_nxt = 1'b1;
    end else if (out_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      h_run_r    <= '0;
      d_hold_r   <= '0;
    end else begin
      cell_vld_r <= cell_vld_nxt;
      res_vld_r  <= res_vld_nxt;
      if (restart) begin
        h_run_r  <= '0;
        d_hold_r <= '0;
      end else if (cell_move) begin
        h_run_r  <= h_new;
        d_hold_r <= d_old;
      end
    end
  end

  // payload, plus forwarding of a same-address write in the read cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r  <= cur;
      byp_r   <= cell_move && (cell_r.pos == cur.pos);
      byp_v_r <= v_new;
      byp_d_r <= d_new;
    end
    if (cell_move) begin
      res_cnt_r  <= cnt;
      res_last_r <= cell_r.last;
    end
  end

  assign out_valid  = res_vld_r;
  assign path_count = res_cnt_r;
  assign is_last    = res_last_r;

endmodule
`default_nettype wire
